// ===== hdl/direction_select_sorter_assert.svh =====
// Assertion macros used by the sorter's top-level RTL file.
`ifndef DIRECTION_SELECT_SORTER_ASSERT_SVH
`define DIRECTION_SELECT_SORTER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorter check failed");
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorter check failed");
`else
`define DSS_ASSERT_NOW(lbl, ante, cons)
`define DSS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/dss_pkg.sv =====
// Types and constants shared by the sorter cell chain and its top level.
package dss_pkg;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;    // place the broadcast item into the sorted chain
    logic shift_lo;  // every cell takes its upper neighbor (pop at cell 0)
    logic shift_hi;  // every cell takes its lower neighbor (pop at last cell)
  } dss_ctrl_t;

endpackage

// ===== hdl/dss_cell.sv =====
// One cell of the insertion chain: holds one value and its valid bit.
module dss_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dss_pkg::dss_ctrl_t ctrl_i,
  input  dss_pkg::data_t    ins_val_i,
  input  dss_pkg::data_t    left_val_i,
  input  logic              left_vld_i,
  input  logic              left_gt_i,
  input  dss_pkg::data_t    right_val_i,
  input  logic              right_vld_i,
  output dss_pkg::data_t    val_o,
  output logic              vld_o,
  output logic              gt_o
);
  import dss_pkg::*;

  data_t val_q, val_d;
  logic  vld_q, vld_d;
  logic  gt;

  // Held value sorts after the incoming one
  assign gt = vld_q && (val_q > ins_val_i);

  // Next contents: insert, shift toward cell 0, or shift toward the end
  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.insert) begin
      if (gt || !vld_q) begin
        if (left_gt_i) begin
          val_d = left_val_i;
          vld_d = 1'b1;
        end else if (left_vld_i) begin
          val_d = ins_val_i;
          vld_d = 1'b1;
        end
      end
    end else if (ctrl_i.shift_lo) begin
      val_d = right_val_i;
      vld_d = right_vld_i;
    end else if (ctrl_i.shift_hi) begin
      val_d = left_val_i;
      vld_d = left_vld_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  assign vld_o = vld_q;
  assign gt_o  = gt;

endmodule

// ===== hdl/direction_select_sorter.sv =====
// Streaming list sorter: a row of insertion cells with a registered output stage.
// Values of a list are taken one per cycle and are placed at once into a chain of
// CAPACITY cells that stays in ascending order; every cell compares the new value
// with its own and either keeps its value, takes its lower neighbor's, or takes the
// new one. The item marked final_item closes the list and starts the readout, during
// which no input item is taken. Readout moves the whole chain by one cell a cycle
// while the output register is free: smallest first pops from cell 0; largest first
// pops from the last cell, so a list shorter than CAPACITY first shifts until its
// largest value arrives there. A new list can start the cycle after the last value
// enters the output register. Values beyond CAPACITY are discarded and flag every
// result of that list with dropped. The descending register in force when the final
// item is taken sets the order.
`include "direction_select_sorter_assert.svh"

module direction_select_sorter #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  // configuration
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_descending_i,
  // input items
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dss_pkg::data_t value_i,
  input  logic           final_item_i,
  // result items
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dss_pkg::data_t sorted_value_o,
  output logic           end_of_list_o,
  output logic           dropped_o
);
  import dss_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] rem_q;
  logic             ovf_q;
  logic             drop_q;
  logic             desc_q;
  logic             dir_q;
  logic             out_valid_q;
  data_t            out_val_q;
  logic             out_eol_q;
  logic             out_drop_q;

  dss_ctrl_t             ctrl;
  data_t                 cell_val [CAPACITY];
  logic [CAPACITY-1:0]   cell_vld;
  logic [CAPACITY-1:0]   cell_gt;
  logic                  in_acc;
  logic                  has_room;
  logic                  advance;
  logic                  pop_vld;
  data_t                 pop_val;
  logic                  pop;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_COLLECT);
  assign in_acc      = in_valid_i && in_ready_o;
  assign has_room    = (cnt_q < CNT_W'(CAPACITY));

  // Chain command for this cycle
  assign advance       = (state_q == ST_DRAIN) && (!out_valid_q || out_ready_i);
  assign ctrl.insert   = in_acc && has_room;
  assign ctrl.shift_lo = advance && !dir_q;
  assign ctrl.shift_hi = advance && dir_q;

  // Pop point: cell 0 for ascending, last cell for descending
  assign pop_vld = dir_q ? cell_vld[CAPACITY-1] : cell_vld[0];
  assign pop_val = dir_q ? cell_val[CAPACITY-1] : cell_val[0];
  assign pop     = advance && pop_vld;

  // Row of insertion cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t left_val, right_val;
    logic  left_vld, left_gt, right_vld;

    if (i == 0) begin : g_head
      assign left_val = '0;
      assign left_vld = ctrl.insert;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_val = cell_val[i-1];
      assign left_vld = cell_vld[i-1];
      assign left_gt  = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = '0;
      assign right_vld = 1'b0;
    end else begin : g_mid
      assign right_val = cell_val[i+1];
      assign right_vld = cell_vld[i+1];
    end

    dss_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .ins_val_i  (value_i),
      .left_val_i (left_val),
      .left_vld_i (left_vld),
      .left_gt_i  (left_gt),
      .right_val_i(right_val),
      .right_vld_i(right_vld),
      .val_o      (cell_val[i]),
      .vld_o      (cell_vld[i]),
      .gt_o       (cell_gt[i])
    );
  end

  // Sequencer: fill count, readout count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      cnt_q       <= '0;
      rem_q       <= '0;
      ovf_q       <= 1'b0;
      drop_q      <= 1'b0;
      desc_q      <= 1'b0;
      dir_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_eol_q   <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        desc_q <= cfg_descending_i;
      end
      // Output valid: set on a pop, cleared once the item is taken
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_COLLECT: begin
          if (in_acc) begin
            if (final_item_i) begin
              state_q <= ST_DRAIN;
              // a write in the same cycle already counts
              dir_q   <= cfg_valid_i ? cfg_descending_i : desc_q;
              rem_q   <= cnt_q + CNT_W'(has_room);
              drop_q  <= ovf_q || !has_room;
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
            end else if (has_room) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              ovf_q <= 1'b1;
            end
          end
        end
        ST_DRAIN: begin
          if (pop) begin
            out_val_q   <= pop_val;
            out_eol_q   <= (rem_q == CNT_W'(1));
            out_drop_q  <= drop_q;
            rem_q       <= rem_q - 1'b1;
            if (rem_q == CNT_W'(1)) begin
              state_q <= ST_COLLECT;
            end
          end
        end
        default: begin
          state_q <= ST_COLLECT;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_val_q;
  assign end_of_list_o  = out_eol_q;
  assign dropped_o      = out_drop_q;

  // Checks
  `DSS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY))
  `DSS_ASSERT_NOW(a_rem_bound, 1'b1, rem_q <= CNT_W'(CAPACITY))
  `DSS_ASSERT_NEXT(a_final_drains, in_acc && final_item_i, (state_q == ST_DRAIN) && !in_ready_o)
  `DSS_ASSERT_NEXT(a_full_flags, in_acc && !final_item_i && !has_room, ovf_q)
  `DSS_ASSERT_NEXT(a_eol_ends_list, pop && (rem_q == CNT_W'(1)), (state_q == ST_COLLECT) && end_of_list_o)

endmodule

// ===== sim/dss_sort_checker.sv =====
`timescale 1ns / 1ps
// Sorter checker: watches all three channels, predicts sorted lists and compares results.
module dss_sort_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  input  logic           cfg_ready_i,
  input  logic           cfg_descending_i,
  input  logic           in_valid_i,
  input  logic           in_ready_i,
  input  dss_pkg::data_t value_i,
  input  logic           final_item_i,
  input  logic           out_valid_i,
  input  logic           out_ready_i,
  input  dss_pkg::data_t sorted_value_i,
  input  logic           end_of_list_i,
  input  logic           dropped_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  import dss_pkg::*;

  // keep the log short when the block is badly broken
  localparam int unsigned REPORT_LINES = 50;

  typedef struct packed {
    data_t value;
    logic  last;
    logic  dropped;
  } sorted_item_t;

  // predictor state: values of the open list, overflow mark, direction
  data_t        list_mem [CAPACITY];
  int           stored_n;
  logic         lost_value;
  logic         largest_first;
  sorted_item_t sorted_due [$];

  initial fail_count_o = 0;

  task automatic report(input string msg);
    if (fail_count_o < REPORT_LINES) begin
      $display("%0t dss_sort_checker: %s", $time, msg);
    end
    fail_count_o++;
  endtask

  // insertion sort of the open list, pushed as one expected item per value
  function automatic void queue_sorted_list();
    data_t ordered [CAPACITY];
    data_t x;
    int    i;
    int    j;
    for (i = 0; i < stored_n; i++) begin
      x = list_mem[i];
      j = i;
      while (j > 0 && (largest_first ? (x > ordered[j-1]) : (x < ordered[j-1]))) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = x;
    end
    for (i = 0; i < stored_n; i++) begin
      sorted_due.push_back('{value: ordered[i], last: (i == stored_n - 1),
                             dropped: lost_value});
    end
  endfunction

  task automatic check_result();
    sorted_item_t want;
    if (sorted_due.size() == 0) begin
      report($sformatf("unexpected result value %0d", sorted_value_i));
      return;
    end
    want = sorted_due.pop_front();
    if (sorted_value_i !== want.value) begin
      report($sformatf("sorted_value got %0d, expected %0d", sorted_value_i, want.value));
    end
    if (end_of_list_i !== want.last) begin
      report($sformatf("end_of_list got %b, expected %b (value %0d)",
                       end_of_list_i, want.last, want.value));
    end
    if (dropped_i !== want.dropped) begin
      report($sformatf("dropped got %b, expected %b (value %0d)",
                       dropped_i, want.dropped, want.value));
    end
  endtask

  task automatic take_value();
    if (stored_n < CAPACITY) begin
      list_mem[stored_n] = value_i;
      stored_n++;
    end else begin
      lost_value = 1'b1;
    end
    // final item closes the list in the direction in force now
    if (final_item_i) begin
      queue_sorted_list();
      stored_n   = 0;
      lost_value = 1'b0;
    end
  endtask

  // channel monitor: config first, then results, then the new input item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_n      = 0;
      lost_value    = 1'b0;
      largest_first = 1'b0;
      sorted_due.delete();
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        largest_first = cfg_descending_i;
      end
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        take_value();
      end
      pending_o <= sorted_due.size();
    end
  end

endmodule

// ===== sim/tb_direction_select_sorter.sv =====
`timescale 1ns / 1ps
// Testbench top for direction_select_sorter: clock, reset, stimulus, idling and verdict.
module tb_direction_select_sorter;
  import dss_pkg::*;

  localparam int unsigned CAPACITY      = 64;
  localparam int unsigned RANDOM_ITEMS  = 480;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam data_t       MOST_NEG      = data_t'(32'h8000_0000);
  localparam data_t       MOST_POS      = data_t'(32'h7FFF_FFFF);

  typedef enum logic {
    ASCENDING  = 1'b0,
    DESCENDING = 1'b1
  } sort_dir_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_descending_i;
  logic        in_valid_i;
  logic        in_ready_o;
  data_t       value_i;
  logic        final_item_i;
  logic        out_valid_o;
  logic        out_ready_i;
  data_t       sorted_value_o;
  logic        end_of_list_o;
  logic        dropped_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned items_sent;

  direction_select_sorter #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_descending_i(cfg_descending_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .value_i         (value_i),
    .final_item_i    (final_item_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sorted_value_o  (sorted_value_o),
    .end_of_list_o   (end_of_list_o),
    .dropped_o       (dropped_o)
  );

  dss_sort_checker #(
    .CAPACITY(CAPACITY)
  ) sort_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_descending_i(cfg_descending_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .value_i         (value_i),
    .final_item_i    (final_item_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sorted_value_i  (sorted_value_o),
    .end_of_list_i   (end_of_list_o),
    .dropped_i       (dropped_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // 125 MHz clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit, far above the slowest correct run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_direction_select_sorter: FAIL");
    $finish;
  end

  // result side: ready with random stalls, mostly short, some long, some none
  initial begin
    int unsigned hold;
    int unsigned r;
    logic        level;
    hold        = 0;
    level       = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold == 0) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          level = 1'b1;
          hold  = $urandom_range(40, 120);
        end else if (r < 55) begin
          level = 1'b1;
          hold  = $urandom_range(1, 8);
        end else if (r < 90) begin
          level = 1'b0;
          hold  = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          hold  = $urandom_range(10, 40);
        end
      end
      out_ready_i <= level;
      hold--;
    end
  end

  // idle cycles before the next input item
  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // extremes, a narrow band that makes duplicates, and full-range values
  function automatic data_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return MOST_NEG;
    if (r < 8) return MOST_POS;
    if (r < 35) return data_t'($signed($urandom_range(0, 8)) - 4);
    return data_t'($urandom);
  endfunction

  task automatic send_value(input data_t v, input logic fin, input int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    value_i      <= v;
    final_item_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // hold the sender until every predicted result is out, then let the chain settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_direction(input sort_dir_e dir);
    wait_idle();
    cfg_valid_i      <= 1'b1;
    cfg_descending_i <= dir;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    int unsigned random_start;
    int unsigned list_no;
    int unsigned len;
    int unsigned split;
    int unsigned r;
    int unsigned k;
    bit          no_gaps;

    rst_ni           = 1'b0;
    cfg_valid_i      = 1'b0;
    cfg_descending_i = 1'b0;
    in_valid_i       = 1'b0;
    value_i          = '0;
    final_item_i     = 1'b0;
    items_sent       = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // smallest first: extremes, zero, a duplicate
    write_direction(ASCENDING);
    send_value(MOST_POS, 1'b0, sender_gap());
    send_value(MOST_NEG, 1'b0, sender_gap());
    send_value(0, 1'b0, sender_gap());
    send_value(-1, 1'b0, sender_gap());
    send_value(1, 1'b0, sender_gap());
    send_value(5, 1'b0, sender_gap());
    send_value(-1, 1'b1, sender_gap());
    // one-value list
    send_value(42, 1'b1, sender_gap());

    // largest first
    write_direction(DESCENDING);
    send_value(MOST_NEG, 1'b0, sender_gap());
    send_value(MOST_POS, 1'b0, sender_gap());
    send_value(-7, 1'b0, sender_gap());
    send_value(3, 1'b0, sender_gap());
    send_value(3, 1'b0, sender_gap());
    send_value(0, 1'b1, sender_gap());
    send_value(MOST_NEG, 1'b1, sender_gap());

    // direction flips while a list is open: the setting at the final item counts
    send_value(9, 1'b0, sender_gap());
    send_value(-9, 1'b0, sender_gap());
    send_value(100, 1'b0, sender_gap());
    write_direction(ASCENDING);
    send_value(-100, 1'b0, sender_gap());
    send_value(0, 1'b1, sender_gap());

    // random lists; a few fill the store or run past it
    random_start = items_sent;
    list_no      = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        write_direction(sort_dir_e'($urandom_range(0, 1)));
      end else if (r < 22) begin
        wait_idle();
      end
      case (list_no)
        2:       len = CAPACITY;
        6:       len = CAPACITY + 1;
        11:      len = CAPACITY + $urandom_range(2, 8);
        default: len = $urandom_range(1, 12);
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      split   = 0;
      if (len >= 3 && len <= 12 && $urandom_range(0, 9) == 0) begin
        split = $urandom_range(1, len - 1);
      end
      for (k = 0; k < len; k++) begin
        if (split != 0 && k == split) begin
          write_direction(sort_dir_e'($urandom_range(0, 1)));
        end
        send_value(pick_value(), (k == len - 1), no_gaps ? 0 : sender_gap());
      end
      list_no++;
    end

    // drain, then allow a full readout's worth of cycles for stray results
    wait_idle();
    repeat (2 * CAPACITY) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_direction_select_sorter: PASS");
    end else begin
      $display("tb_direction_select_sorter: FAIL");
    end
    $finish;
  end

endmodule

// ===== direction_select_sorter.f =====
+incdir+hdl
hdl/dss_pkg.sv
hdl/dss_cell.sv
hdl/direction_select_sorter.sv
sim/dss_sort_checker.sv
sim/tb_direction_select_sorter.sv
